/* rtl/pbae_pkg.sv */
// ----------------------------------------------------------------------------
// pbae_pkg
// Shared types and constants for the packed bit array engine.
// ----------------------------------------------------------------------------
package pbae_pkg;

  typedef enum logic [2:0] {
    OP_FILL      = 3'd0,
    OP_LOAD      = 3'd1,
    OP_COUNT     = 3'd2,
    OP_FIND      = 3'd3,
    OP_FLIP      = 3'd4,
    OP_MERGE_AND = 3'd5,
    OP_MERGE_OR  = 3'd6,
    OP_READ      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_EXEC,
    S_DONE
  } state_e;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

endpackage

/* rtl/packed_bit_array_engine_top.sv */
// ----------------------------------------------------------------------------
// packed_bit_array_engine_top
// Byte-organized bit store with fill, load, flip, count, find, merge, read.
// ----------------------------------------------------------------------------
// Each byte of a command's span passes through the read, wait and execute
// states of the shared read-modify-write unit, then the result is registered
// from the done state once the output is free; a rejected or empty command goes
// straight from idle to the done state. Fill, flip and length changes sweep the
// whole store; load, merge and read touch one or two bytes. One command is in
// work at a time. Reset clears control state and sets the full length; the store is undefined.
module packed_bit_array_engine_top #(
  parameter int unsigned NUM_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], fill_value[3], begin_pos[16:4], end_pos[29:17], to_end[30],
  // byte_index[39:31], data_byte[47:40], merge_bits[55:48],
  // merge_count[59:56], dest_offset[71:60], zero[79:72]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bit_count[12:0], found[13], position[25:14], read_data[33:26],
  // status[35:34], zero[39:36]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  localparam int unsigned Bytes = (NUM_BITS + 7) / 8;
  localparam int unsigned AW    = (Bytes > 1) ? $clog2(Bytes) : 1;
  localparam int unsigned LW    = $clog2(NUM_BITS + 1);

  pbae_pkg::state_e state_q, state_d;

  logic [2:0]  op_q;
  logic        fv_q;
  logic [12:0] bpos_q, end_q;
  logic [7:0]  dbyte_q, mbits_q;
  logic [3:0]  mcnt_q;
  logic [11:0] doff_q;
  logic        clr_q;
  logic [LW-1:0] len_q;
  logic [AW:0] addr_q, addr_d, last_q;
  logic [12:0] cnt_q, cnt_d;
  logic        fnd_q, fnd_d;
  logic [11:0] pos_q, pos_d;
  logic [15:0] win_q, win_d;
  logic [1:0]  st_q;
  logic [39:0] res_q;
  logic [7:0]  rdata;
  logic        we;
  logic [7:0]  wdata;
  logic        out_free;

  logic [2:0]  in_op;
  logic [12:0] in_bpos, in_epos, in_end;
  logic [8:0]  in_bidx;
  logic [3:0]  in_mcnt;
  logic [11:0] in_doff;
  logic [13:0] len_ext;
  logic [1:0]  in_st;
  logic        in_empty;
  logic [AW:0] in_first, in_last;

  logic [12:0] cfg_len;
  assign cfg_len = (cfg_wdata == 13'd0) ? 13'd1 :
                   ({1'b0, cfg_wdata} > 14'(NUM_BITS)) ? 13'(NUM_BITS) : cfg_wdata;

  assign in_op   = s_axis_tdata[2:0];
  assign in_bpos = s_axis_tdata[16:4];
  assign in_epos = s_axis_tdata[29:17];
  assign in_bidx = s_axis_tdata[39:31];
  assign in_mcnt = s_axis_tdata[59:56];
  assign in_doff = s_axis_tdata[71:60];
  assign len_ext = 14'(len_q);
  assign in_end  = s_axis_tdata[30] ? 13'(len_q) : in_epos;

  always_comb begin
    in_st    = pbae_pkg::ST_OK;
    in_empty = 1'b0;
    in_first = '0;
    in_last  = (AW+1)'(Bytes - 1);
    case (pbae_pkg::op_e'(in_op))
      pbae_pkg::OP_LOAD: begin
        if ({2'b0, in_bidx, 3'b0} >= len_ext) in_st = pbae_pkg::ST_INVALID;
        in_first = (AW+1)'(in_bidx);
        in_last  = (AW+1)'(in_bidx);
      end
      pbae_pkg::OP_COUNT, pbae_pkg::OP_FIND, pbae_pkg::OP_READ: begin
        if (in_bpos == in_end) in_empty = 1'b1;
        else if (in_bpos > in_end || {1'b0, in_end} > len_ext) in_st = pbae_pkg::ST_INVALID;
        in_first = (AW+1)'(in_bpos >> 3);
        if (in_op == pbae_pkg::OP_READ) in_last = (AW+1)'((in_bpos >> 3) + 13'd1);
        else in_last = (AW+1)'((in_end - 13'd1) >> 3);
      end
      pbae_pkg::OP_MERGE_AND, pbae_pkg::OP_MERGE_OR: begin
        if (in_mcnt == 4'd0) in_empty = 1'b1;
        else if (in_mcnt > 4'd8) in_st = pbae_pkg::ST_INVALID;
        else if ({2'b0, in_doff} + {10'd0, in_mcnt} > len_ext)
          in_st = pbae_pkg::ST_OVERFLOW;
        in_first = (AW+1)'(in_doff >> 3);
        in_last  = (AW+1)'((in_doff + 12'(in_mcnt) - 12'd1) >> 3);
      end
      default: ;
    endcase
    if (in_last > (AW+1)'(Bytes - 1)) in_last = (AW+1)'(Bytes - 1);
  end

  assign s_axis_tready = (state_q == pbae_pkg::S_IDLE) && !cfg_we;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Bit index of bit 0 of the current byte.
  logic [16:0] base;
  logic [7:0]  keep, sel, mmask, msrc;
  logic [15:0] mshift;
  assign base = 17'({addr_q[AW-1:0], 3'b0});

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep[i] = (17'(base) + 17'(i)) < 17'(len_q);
      sel[i]  = (17'(base) + 17'(i)) >= 17'(bpos_q) && (17'(base) + 17'(i)) < 17'(end_q);
    end
    mshift = ({8'd0, mbits_q} << doff_q[2:0]);
    mmask  = 8'd0;
    msrc   = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if ((17'(base) + 17'(i)) >= 17'(doff_q) &&
          (17'(base) + 17'(i)) < 17'(doff_q) + 17'(mcnt_q)) mmask[i] = 1'b1;
      msrc[i] = (addr_q[AW-1:0] == doff_q[AW+2:3]) ? mshift[i] : mshift[i+8];
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (state_q == pbae_pkg::S_EXEC) begin
      we = 1'b1;
      if (clr_q) wdata = rdata & keep;
      else begin
        case (pbae_pkg::op_e'(op_q))
          pbae_pkg::OP_FILL:  wdata = fv_q ? keep : 8'd0;
          pbae_pkg::OP_FLIP:  wdata = ~rdata & keep;
          pbae_pkg::OP_LOAD:  wdata = dbyte_q & keep;
          pbae_pkg::OP_MERGE_AND: wdata = (rdata & ~mmask) | (rdata & msrc & mmask);
          pbae_pkg::OP_MERGE_OR:  wdata = rdata | (msrc & mmask);
          default: we = 1'b0;
        endcase
      end
    end
  end

  logic [7:0] fmatch;
  logic [2:0] fidx;
  logic       fany;
  always_comb begin
    fmatch = (fv_q ? rdata : ~rdata) & sel;
    fidx = 3'd0;
    fany = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (fmatch[i]) begin
        fidx = 3'(i);
        fany = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    fnd_d = fnd_q;
    pos_d = pos_q;
    win_d = win_q;
    addr_d = addr_q;
    if (state_q == pbae_pkg::S_IDLE) begin
      if (cfg_we) begin
        addr_d = '0;
      end else if (s_axis_tvalid && s_axis_tready) begin
        addr_d = in_first;
        cnt_d  = '0;
        fnd_d  = 1'b0;
        pos_d  = '0;
        win_d  = '0;
      end
    end else if (state_q == pbae_pkg::S_EXEC) begin
      addr_d = addr_q + 1'b1;
      if (!clr_q) begin
        case (pbae_pkg::op_e'(op_q))
          pbae_pkg::OP_COUNT: cnt_d = cnt_q + 13'(pbae_pkg::popcount8(rdata & sel));
          pbae_pkg::OP_FIND: if (!fnd_q && fany) begin
            fnd_d = 1'b1;
            pos_d = 12'(base) + 12'(fidx);
          end
          pbae_pkg::OP_READ: begin
            if (addr_q[AW-1:0] == bpos_q[AW+2:3]) win_d[7:0] = rdata & sel;
            else win_d[15:8] = rdata & sel;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbae_pkg::S_IDLE: if (cfg_we || (s_axis_tvalid && s_axis_tready)) begin
        state_d = pbae_pkg::S_READ;
        if (!cfg_we && (in_st != pbae_pkg::ST_OK || in_empty)) state_d = pbae_pkg::S_DONE;
      end
      pbae_pkg::S_READ: state_d = pbae_pkg::S_WAIT;
      pbae_pkg::S_WAIT: state_d = pbae_pkg::S_EXEC;
      pbae_pkg::S_EXEC: state_d = (addr_q == last_q) ? pbae_pkg::S_DONE : pbae_pkg::S_READ;
      pbae_pkg::S_DONE: state_d = out_free ? pbae_pkg::S_IDLE : pbae_pkg::S_DONE;
      default: state_d = pbae_pkg::S_IDLE;
    endcase
  end

  logic [15:0] rd_sh;
  assign rd_sh = win_q >> bpos_q[2:0];

  pbae_ram #(.Width(8), .Depth(Bytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbae_pkg::S_IDLE;
      len_q   <= LW'(NUM_BITS);
      m_axis_tvalid <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) len_q <= LW'(cfg_len);
      if (state_q == pbae_pkg::S_IDLE) clr_q <= cfg_we;
      if (state_q == pbae_pkg::S_DONE && out_free && !clr_q) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    fnd_q  <= fnd_d;
    pos_q  <= pos_d;
    win_q  <= win_d;
    if (state_q == pbae_pkg::S_IDLE) begin
      if (cfg_we) begin
        last_q <= (AW+1)'(Bytes - 1);
      end else if (s_axis_tvalid && s_axis_tready) begin
        op_q    <= in_op;
        fv_q    <= s_axis_tdata[3];
        bpos_q  <= in_bpos;
        end_q   <= in_end;
        dbyte_q <= s_axis_tdata[47:40];
        mbits_q <= s_axis_tdata[55:48];
        mcnt_q  <= in_mcnt;
        doff_q  <= in_doff;
        st_q    <= in_st;
        last_q  <= in_last;
      end
    end
    if (state_q == pbae_pkg::S_DONE && out_free && !clr_q) begin
      res_q <= {4'd0, st_q, ((op_q == pbae_pkg::OP_READ) ? rd_sh[7:0] : 8'd0),
                pos_q, fnd_q, cnt_q};
    end
  end

  assign m_axis_tdata = res_q;

endmodule

/* rtl/pbae_ram.sv */
// ----------------------------------------------------------------------------
// pbae_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbae_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
